>>> hw/rtl/lkc_pkg.sv
// lkc_pkg: shared types and constants for the lru key cache lookup
// no dependencies

package lkc_pkg;

  localparam int KEY_W     = 64;
  localparam int CAP_W     = 5;
  localparam int ENTRIES_D = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef struct packed {
    logic compare;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/lkc_cell.sv
// lkc_cell: one position of the recency chain, holds a key and compares it
// depends on lkc_pkg

module lkc_cell
  import lkc_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int POS_W = 4
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [POS_W-1:0] pos,
  input  logic [KEY_W-1:0] lookup,
  input  logic [KEY_W-1:0] prev_key,
  output logic [KEY_W-1:0] key,
  output logic             match
);

  logic take;

  assign take = ctrl.shift && (POS_W'(INDEX) <= pos);

  always_ff @(posedge clk) begin
    if (take) begin
      key <= prev_key;
    end
    if (ctrl.compare) begin
      match <= (key == lookup);
    end
  end

endmodule

>>> hw/rtl/lru_key_cache_lookup.sv
// lru_key_cache_lookup: top level, controller around a chain of key cells
// depends on lkc_pkg and lkc_cell

// Fully associative key cache with least-recently-used replacement. The keys
// sit in a chain of ENTRIES cells, most recent first. Each key passes two steps:
// in the compare step every cell compares its stored key with the lookup key and
// registers the result, in the update step the controller finds the hit position
// (or the insert position on a miss) and the cells from the front of the chain up
// to it take their neighbor's key in one shift. The next key can be accepted as
// the update step finishes, so a key is taken while the last one completes. The
// result word waits in an output register; the update stalls only while that
// register still holds an untaken word. The capacity register is written
// through its own channel, always ready.

module lru_key_cache_lookup
  import lkc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_D
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] capacity,
  input  logic             key_valid,
  output logic             key_ready,
  input  logic [KEY_W-1:0] key,
  output logic             res_valid,
  input  logic             res_ready,
  output logic             hit,
  output logic             evicted
);

  localparam int POS_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CAP_W-1:0] cap_reg;
  logic [OCC_W-1:0] occupancy;
  logic [OCC_W-1:0] occupancy_next;
  logic [KEY_W-1:0] lookup;

  logic [OCC_W-1:0] ecap;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] hit_vec;
  logic [KEY_W-1:0] chain [ENTRIES];
  logic [POS_W-1:0] hit_pos;
  logic [POS_W-1:0] pos;
  logic             hit_now;
  logic             evict_now;
  logic             finish;
  logic             accept;
  cell_ctrl_t       ctrl;

  assign cfg_ready = 1'b1;

  // effective capacity: zero acts as one, large values saturate
  always_comb begin
    if (cap_reg == '0) begin
      ecap = OCC_W'(1);
    end else if (CW'(cap_reg) > CW'(ENTRIES)) begin
      ecap = OCC_W'(ENTRIES);
    end else begin
      ecap = OCC_W'(cap_reg);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = match[i] && (OCC_W'(i) < occupancy);
      hit_pos    = hit_pos | (hit_vec[i] ? POS_W'(i) : '0);
    end
  end

  assign hit_now = |hit_vec;

  always_comb begin
    evict_now      = 1'b0;
    occupancy_next = occupancy;
    pos            = hit_pos;
    if (!hit_now) begin
      if (occupancy >= ecap) begin
        evict_now      = 1'b1;
        pos            = POS_W'(ecap - OCC_W'(1));
        occupancy_next = ecap;
      end else begin
        pos            = POS_W'(occupancy);
        occupancy_next = occupancy + OCC_W'(1);
      end
    end
  end

  assign finish    = (state == S_UPD) && (!res_valid || res_ready);
  assign key_ready = (state == S_IDLE) || finish;
  assign accept    = key_valid && key_ready;

  assign ctrl = cell_ctrl_t'{compare: (state == S_CMP), shift: finish};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (finish) begin
          state_next = accept ? S_CMP : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap_reg   <= CAP_RESET;
      occupancy <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        cap_reg <= capacity;
      end
      if (finish) begin
        occupancy <= occupancy_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lookup <= key;
    end
    if (finish) begin
      hit     <= hit_now;
      evicted <= evict_now;
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkc_cell #(
      .INDEX (g),
      .POS_W (POS_W)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .pos      (pos),
      .lookup   (lookup),
      .prev_key ((g == 0) ? lookup : chain[(g == 0) ? 0 : g - 1]),
      .key      (chain[g]),
      .match    (match[g])
    );
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(ENTRIES))
    else $error("occupancy above entry count");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(hit && evicted))
    else $error("eviction reported on a hit");

  a_hit_keeps_occ: assert property (@(posedge clk) disable iff (rst)
    finish && hit_now |=> $stable(occupancy))
    else $error("occupancy changed on a hit");

  a_miss_grows: assert property (@(posedge clk) disable iff (rst)
    finish && !hit_now && !evict_now |=> occupancy == $past(occupancy) + OCC_W'(1))
    else $error("occupancy did not grow on a plain miss");

  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> $onehot0(hit_vec))
    else $error("key found at more than one position");
`endif

endmodule
